@@ hdl/hcs_pkg.sv @@
package hcs_pkg;

    // Field and datapath widths
    localparam int unsigned MAX_BANDS = 8;
    localparam int unsigned BAND_W    = 16;
    localparam int unsigned ISQ_W     = 36;
    localparam int unsigned PSQ_W     = 33;
    localparam int unsigned NUM_W     = 72;
    localparam int unsigned PROD_W    = 104;
    localparam int unsigned QUO_W     = 32;
    localparam int unsigned SQ_STAGES = 8;

    // Pipeline depths
    localparam int unsigned GAIN_LAT  = 5;
    localparam int unsigned LANE_LAT  = 3 + QUO_W + SQ_STAGES;

    // Register indexes
    localparam logic [1:0] REG_ISQ_MEAN   = 2'd0;
    localparam logic [1:0] REG_ISQ_SPREAD = 2'd1;
    localparam logic [1:0] REG_PSQ_MEAN   = 2'd2;
    localparam logic [1:0] REG_PSQ_SPREAD = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic                     bad;
        logic signed [NUM_W-1:0]  num;
        logic signed [NUM_W-1:0]  den;
    } gain_t;

    typedef struct packed {
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] root;
    } sqrt_state_t;

    // One bit-pair step of the integer square root
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [QUO_W-1:0] bitv);
        sqrt_state_t r;
        logic [QUO_W:0] trial;
        trial = {1'b0, s.root} + {1'b0, bitv};
        if ({1'b0, s.rem} >= trial)
        begin
            r.rem  = s.rem - trial[QUO_W-1:0];
            r.root = (s.root >> 1) + bitv;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

@@ hdl/hcs_gain.sv @@
module hcs_gain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [hcs_pkg::BAND_W-1:0]    pan,
    input  logic [hcs_pkg::BAND_W-1:0]    pan_smooth,
    input  logic [hcs_pkg::ISQ_W-1:0]     isq_mean,
    input  logic [hcs_pkg::ISQ_W-1:0]     isq_spread,
    input  logic [hcs_pkg::PSQ_W-1:0]     psq_mean,
    input  logic [hcs_pkg::PSQ_W-1:0]     psq_spread,
    output hcs_pkg::gain_t                gain
);
    import hcs_pkg::*;

    logic [4:0]               valid_reg;
    logic [31:0]              p2_reg, ps2_reg;
    logic signed [34:0]       dp_reg, ds_reg;
    logic signed [36:0]       dt_reg;
    logic signed [53:0]       pnl_reg, pnh_reg, pdl_reg, pdh_reg;
    logic signed [54:0]       tl_reg;
    logic signed [53:0]       th_reg;
    logic signed [NUM_W-1:0]  t1n_reg, t1d_reg, t2_reg;
    logic signed [NUM_W-1:0]  num_reg, den_reg;
    logic                     bad_reg;
    logic signed [NUM_W-1:0]  num_next, den_next;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    assign num_next = t1n_reg + t2_reg;
    assign den_next = t1d_reg + t2_reg;

    // Square, offset, partial products, sums, gain terms
    always_ff @(posedge clk)
    begin
        p2_reg  <= 32'(pan) * 32'(pan);
        ps2_reg <= 32'(pan_smooth) * 32'(pan_smooth);

        dp_reg <= $signed({3'b0, p2_reg}) + $signed({2'b0, psq_spread})
                  - $signed({2'b0, psq_mean});
        ds_reg <= $signed({3'b0, ps2_reg}) + $signed({2'b0, psq_spread})
                  - $signed({2'b0, psq_mean});
        dt_reg <= $signed({1'b0, isq_mean}) - $signed({1'b0, isq_spread});

        pnl_reg <= 54'(dp_reg) * 54'($signed({1'b0, isq_spread[17:0]}));
        pnh_reg <= 54'(dp_reg) * 54'($signed({1'b0, isq_spread[35:18]}));
        pdl_reg <= 54'(ds_reg) * 54'($signed({1'b0, isq_spread[17:0]}));
        pdh_reg <= 54'(ds_reg) * 54'($signed({1'b0, isq_spread[35:18]}));
        tl_reg  <= 55'(dt_reg) * 55'($signed({1'b0, psq_spread[16:0]}));
        th_reg  <= 54'(dt_reg) * 54'($signed({1'b0, psq_spread[32:17]}));

        t1n_reg <= NUM_W'(pnl_reg) + (NUM_W'(pnh_reg) <<< 18);
        t1d_reg <= NUM_W'(pdl_reg) + (NUM_W'(pdh_reg) <<< 18);
        t2_reg  <= NUM_W'(tl_reg) + (NUM_W'(th_reg) <<< 17);

        num_reg <= num_next;
        den_reg <= den_next;
        bad_reg <= (psq_spread == '0) || (den_next <= 0) || (num_next < 0);
    end

    assign gain.valid = valid_reg[4];
    assign gain.bad   = bad_reg;
    assign gain.num   = num_reg;
    assign gain.den   = den_reg;

endmodule

@@ hdl/hcs_lane.sv @@
module hcs_lane (
    input  logic                                clk,
    input  logic [hcs_pkg::BAND_W-1:0]          band,
    input  logic signed [hcs_pkg::NUM_W-1:0]    num,
    input  logic signed [hcs_pkg::NUM_W-1:0]    den,
    output logic [hcs_pkg::BAND_W-1:0]          res
);
    import hcs_pkg::*;

    logic [31:0]         b2_reg;
    logic [NUM_W-1:0]    num1_reg, den1_reg, den2_reg;
    logic [67:0]         pl_reg, ph_reg;
    logic [PROD_W-1:0]   rem_reg [0:QUO_W];
    logic [NUM_W-1:0]    den_reg [0:QUO_W-1];
    logic [QUO_W-1:0]    q_reg   [1:QUO_W];
    logic                sat_reg [1:QUO_W];
    sqrt_state_t         sq_reg  [1:SQ_STAGES];
    logic                sats_reg[1:SQ_STAGES];

    // Square the band and form the scaled product
    always_ff @(posedge clk)
    begin
        b2_reg     <= 32'(band) * 32'(band);
        num1_reg   <= num;
        den1_reg   <= den;
        pl_reg     <= 68'(b2_reg) * 68'(num1_reg[35:0]);
        ph_reg     <= 68'(b2_reg) * 68'(num1_reg[71:36]);
        den2_reg   <= den1_reg;
        rem_reg[0] <= PROD_W'(pl_reg) + (PROD_W'(ph_reg) << 36);
        den_reg[0] <= den2_reg;
    end

    // Restoring division, one quotient bit per stage
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        localparam int unsigned K = QUO_W - 1 - i;
        logic [PROD_W-1:0] d;
        logic [QUO_W-1:0]  q_in;
        logic              sat_in;
        assign d = PROD_W'(den_reg[i]) << K;
        if (i == 0)
        begin : g_first
            assign q_in   = '0;
            assign sat_in = rem_reg[0] >= (PROD_W'(den_reg[0]) << QUO_W);
        end
        else
        begin : g_rest
            assign q_in   = q_reg[i];
            assign sat_in = sat_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (rem_reg[i] >= d)
            begin
                rem_reg[i+1] <= rem_reg[i] - d;
                q_reg[i+1]   <= q_in | (QUO_W'(1) << K);
            end
            else
            begin
                rem_reg[i+1] <= rem_reg[i];
                q_reg[i+1]   <= q_in;
            end
            sat_reg[i+1] <= sat_in;
        end
        if (i < QUO_W - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    // Integer square root, two steps per stage
    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_sqrt
        localparam int unsigned SH0 = QUO_W - 2 - 4 * s;
        localparam int unsigned SH1 = QUO_W - 4 - 4 * s;
        sqrt_state_t st_in, st_mid;
        logic        sat_in;
        if (s == 0)
        begin : g_first
            assign st_in.rem  = q_reg[QUO_W];
            assign st_in.root = '0;
            assign sat_in     = sat_reg[QUO_W];
        end
        else
        begin : g_rest
            assign st_in  = sq_reg[s];
            assign sat_in = sats_reg[s];
        end
        assign st_mid = sqrt_step(st_in, QUO_W'(1) << SH0);
        always_ff @(posedge clk)
        begin
            sq_reg[s+1]   <= sqrt_step(st_mid, QUO_W'(1) << SH1);
            sats_reg[s+1] <= sat_in;
        end
    end

    assign res = sats_reg[SQ_STAGES] ? '1 : sq_reg[SQ_STAGES].root[BAND_W-1:0];

endmodule

@@ hdl/hcs_pan_sharpen_pixel.sv @@
// Hyperspherical pan sharpening, one pixel per clock. A request is taken
// whenever start is high (busy stays low), and its result appears on the
// out ports with done high for one cycle, after the gain arithmetic, band
// scaling, restoring division (one quotient bit per stage), square root
// and the output register. Results cannot be held off; capture them when
// done is high. Bands at or above NUM_BANDS read as zero. The statistic
// registers are written through wr_en/wr_index/wr_data and must only change
// while no pixel is in flight.
module hcs_pan_sharpen_pixel #(
    parameter int unsigned NUM_BANDS = hcs_pkg::MAX_BANDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        wr_en,
    input  logic [1:0]                  wr_index,
    input  logic [hcs_pkg::ISQ_W-1:0]   wr_data,
    input  logic [hcs_pkg::BAND_W-1:0]  band_0,
    input  logic [hcs_pkg::BAND_W-1:0]  band_1,
    input  logic [hcs_pkg::BAND_W-1:0]  band_2,
    input  logic [hcs_pkg::BAND_W-1:0]  band_3,
    input  logic [hcs_pkg::BAND_W-1:0]  band_4,
    input  logic [hcs_pkg::BAND_W-1:0]  band_5,
    input  logic [hcs_pkg::BAND_W-1:0]  band_6,
    input  logic [hcs_pkg::BAND_W-1:0]  band_7,
    input  logic [hcs_pkg::BAND_W-1:0]  pan,
    input  logic [hcs_pkg::BAND_W-1:0]  pan_smooth,
    output logic                        done,
    output logic [hcs_pkg::BAND_W-1:0]  out_0,
    output logic [hcs_pkg::BAND_W-1:0]  out_1,
    output logic [hcs_pkg::BAND_W-1:0]  out_2,
    output logic [hcs_pkg::BAND_W-1:0]  out_3,
    output logic [hcs_pkg::BAND_W-1:0]  out_4,
    output logic [hcs_pkg::BAND_W-1:0]  out_5,
    output logic [hcs_pkg::BAND_W-1:0]  out_6,
    output logic [hcs_pkg::BAND_W-1:0]  out_7,
    output logic                        invalid
);
    import hcs_pkg::*;

    logic [ISQ_W-1:0]  isq_mean_reg, isq_spread_reg;
    logic [PSQ_W-1:0]  psq_mean_reg, psq_spread_reg;
    gain_t             gain;
    logic [BAND_W-1:0] band_in  [0:MAX_BANDS-1];
    logic [BAND_W-1:0] band_dly_reg [0:GAIN_LAT-1][0:MAX_BANDS-1];
    logic [BAND_W-1:0] lane_res [0:MAX_BANDS-1];
    logic [LANE_LAT-1:0] val_reg, bad_reg;
    logic              done_reg, invalid_reg;
    logic [BAND_W-1:0] out_reg  [0:MAX_BANDS-1];

    assign busy = 1'b0;

    // Write statistic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isq_mean_reg   <= '0;
            isq_spread_reg <= ISQ_W'(1);
            psq_mean_reg   <= '0;
            psq_spread_reg <= PSQ_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ISQ_MEAN:   isq_mean_reg   <= wr_data;
                REG_ISQ_SPREAD: isq_spread_reg <= wr_data;
                REG_PSQ_MEAN:   psq_mean_reg   <= wr_data[PSQ_W-1:0];
                REG_PSQ_SPREAD: psq_spread_reg <= wr_data[PSQ_W-1:0];
                default: ;
            endcase
        end
    end

    hcs_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .pan        (pan),
        .pan_smooth (pan_smooth),
        .isq_mean   (isq_mean_reg),
        .isq_spread (isq_spread_reg),
        .psq_mean   (psq_mean_reg),
        .psq_spread (psq_spread_reg),
        .gain       (gain)
    );

    assign band_in[0] = band_0;
    assign band_in[1] = band_1;
    assign band_in[2] = band_2;
    assign band_in[3] = band_3;
    assign band_in[4] = band_4;
    assign band_in[5] = band_5;
    assign band_in[6] = band_6;
    assign band_in[7] = band_7;

    // Hold bands until the gain is ready
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            band_dly_reg[0][k] <= band_in[k];
            for (int j = 1; j < GAIN_LAT; j++)
                band_dly_reg[j][k] <= band_dly_reg[j-1][k];
        end
    end

    for (genvar k = 0; k < MAX_BANDS; k++)
    begin : g_lane
        if (k < NUM_BANDS)
        begin : g_used
            hcs_lane u_lane (
                .clk  (clk),
                .band (band_dly_reg[GAIN_LAT-1][k]),
                .num  (gain.num),
                .den  (gain.den),
                .res  (lane_res[k])
            );
        end
        else
        begin : g_unused
            assign lane_res[k] = '0;
        end
    end

    // Advance valid and bad flags alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            bad_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            val_reg  <= {val_reg[LANE_LAT-2:0], gain.valid};
            bad_reg  <= {bad_reg[LANE_LAT-2:0], gain.bad};
            done_reg <= val_reg[LANE_LAT-1];
        end
    end

    // Register results, zero them on undefined gain
    always_ff @(posedge clk)
    begin
        invalid_reg <= bad_reg[LANE_LAT-1];
        for (int k = 0; k < MAX_BANDS; k++)
            out_reg[k] <= bad_reg[LANE_LAT-1] ? '0 : lane_res[k];
    end

    assign done    = done_reg;
    assign invalid = invalid_reg;
    assign out_0   = out_reg[0];
    assign out_1   = out_reg[1];
    assign out_2   = out_reg[2];
    assign out_3   = out_reg[3];
    assign out_4   = out_reg[4];
    assign out_5   = out_reg[5];
    assign out_6   = out_reg[6];
    assign out_7   = out_reg[7];

endmodule
